[hw/rtl/smr_pkg.sv]
`default_nettype none

package smr_pkg;

    // command carried in s_tuser
    typedef enum logic [1:0] {
        CMD_XFER  = 2'd0,
        CMD_BIND  = 2'd1,
        CMD_END   = 2'd2,
        CMD_SPARE = 2'd3
    } cmd_t;

    // bind target codes
    typedef enum logic [1:0] {
        TGT_LEFT  = 2'd0,
        TGT_RIGHT = 2'd1,
        TGT_X     = 2'd2,
        TGT_Y     = 2'd3
    } target_t;

    // exchange phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_READY  = 7'b0000010,
        PH_ID_HI  = 7'b0000100,
        PH_BTN_LO = 7'b0001000,
        PH_BTN_HI = 7'b0010000,
        PH_MOT_X  = 7'b0100000,
        PH_MOT_Y  = 7'b1000000
    } phase_t;

    // register indexes
    localparam logic REG_SENS_H = 1'b0;
    localparam logic REG_SENS_V = 1'b1;

    localparam logic [15:0] DEVICE_ID    = 16'h5A12;
    localparam logic [7:0]  BYTE_START   = 8'h01;
    localparam logic [7:0]  BYTE_POLL    = 8'h42;
    localparam logic [7:0]  BYTE_IDLE    = 8'hFF;
    localparam logic [15:0] BUTTONS_OFF  = 16'hFFFF;
    localparam int          LEFT_BIT     = 11;
    localparam int          RIGHT_BIT    = 10;
    localparam logic signed [15:0] PRESS_LEVEL = 16'sd128;
    localparam logic [11:0] SENS_RESET   = 12'd256;

    // fields of one input beat
    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         host_byte;
        logic [1:0]         bind_target;
        logic signed [15:0] amount;
    } in_item_t;

    // fields of one result beat
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       acknowledge;
        logic [1:0] held_buttons;
    } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/serial_mouse_responder_core.sv]
`default_nettype none

// game-port mouse responder
// s_* channel: one beat per event; s_tuser carries the command (transfer,
//   bind update, end of transfer), s_tdata the byte, bind target and amount
// m_* channel: exactly one beat per input beat, in order: reply byte,
//   acknowledge flag and the buttons held after that event
// apb port: two 12-bit Q4.8 gain registers, X at 0x0, Y at 0x4; write them
//   only while no beat is in flight
// data path: an accepted beat is registered into the input stage, worked out
//   combinationally and registered into the result register when the output
//   side is free
// throughput: one beat per cycle unless m_tready holds the result register;
//   the phase update, the gain multiply with its saturating add and the
//   report clamp all sit between the input stage and the result register
// a stalled result holds in the result register while the input stage
//   still takes one more beat; s_tready drops only when both are full
// reset: phase idle, buttons all released, accumulators zero, gains 1.0,
//   both stages empty
module serial_mouse_responder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // host_byte[7:0] bind_target[9:8] amount[25:10]
    input  wire logic [1:0]  s_tuser,  // cmd[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata   // reply_byte[7:0] acknowledge[8] held_buttons[10:9]
);

    // configuration registers
    logic [11:0] sens_h_reg;
    logic [11:0] sens_v_reg;

    // block state
    smr_pkg::phase_t    phase_reg, phase_next;
    logic [15:0]        buttons_reg, buttons_next;
    logic signed [31:0] acc_x_reg, acc_x_next;
    logic signed [31:0] acc_y_reg, acc_y_next;

    // pipeline stages
    logic                 in_valid_reg;
    smr_pkg::in_item_t    in_item_reg;
    logic                 out_valid_reg;
    smr_pkg::out_item_t   out_item_reg, out_item_next;

    logic advance;
    logic fire;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == smr_pkg::REG_SENS_V)
            prdata = {20'd0, sens_v_reg};
        else
            prdata = {20'd0, sens_h_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_h_reg <= smr_pkg::SENS_RESET;
            sens_v_reg <= smr_pkg::SENS_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == smr_pkg::REG_SENS_V)
                sens_v_reg <= pwdata[11:0];
            else
                sens_h_reg <= pwdata[11:0];
        end
    end

    // handshake: result register frees up when empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.cmd         <= s_tuser;
            in_item_reg.host_byte   <= s_tdata[7:0];
            in_item_reg.bind_target <= s_tdata[9:8];
            in_item_reg.amount      <= s_tdata[25:10];
        end
    end

    // motion bind: amount * gain (Q12.16), floored to 8 fraction bits
    logic [11:0]        sens_sel;
    logic signed [12:0] sens_signed;
    logic signed [28:0] product;
    logic signed [20:0] increment;
    logic signed [31:0] acc_sel;
    logic signed [32:0] sum_wide;
    logic signed [31:0] acc_added;

    assign sens_sel    = (in_item_reg.bind_target == smr_pkg::TGT_Y) ? sens_v_reg : sens_h_reg;
    assign acc_sel     = (in_item_reg.bind_target == smr_pkg::TGT_Y) ? acc_y_reg : acc_x_reg;
    assign sens_signed = $signed({1'b0, sens_sel});
    assign product     = 29'($signed(in_item_reg.amount)) * 29'(sens_signed);
    assign increment   = product[28:8];
    assign sum_wide    = {acc_sel[31], acc_sel} + {{12{increment[20]}}, increment};

    // saturate at the signed 32-bit limits
    always_comb
    begin
        if (sum_wide[32] != sum_wide[31])
            acc_added = sum_wide[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            acc_added = sum_wide[31:0];
    end

    // motion report: floor of the integer part, clamped to -128..127
    logic signed [31:0] acc_rep;
    logic [7:0]         motion_byte;

    assign acc_rep = (phase_reg == smr_pkg::PH_MOT_Y) ? acc_y_reg : acc_x_reg;

    always_comb
    begin
        if (!acc_rep[31] && (acc_rep[30:15] != 16'd0))
            motion_byte = 8'h7F;
        else if (acc_rep[31] && (acc_rep[30:15] != 16'hFFFF))
            motion_byte = 8'h80;
        else
            motion_byte = acc_rep[15:8];
    end

    // one event: phase step, button update or motion accumulate
    logic [7:0] reply;
    logic       ack;

    always_comb
    begin
        phase_next   = phase_reg;
        buttons_next = buttons_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        reply        = smr_pkg::BYTE_IDLE;
        ack          = 1'b0;

        case (smr_pkg::cmd_t'(in_item_reg.cmd))
            smr_pkg::CMD_XFER:
            begin
                case (phase_reg)
                    smr_pkg::PH_IDLE:
                    begin
                        if (in_item_reg.host_byte == smr_pkg::BYTE_START)
                        begin
                            phase_next = smr_pkg::PH_READY;
                            ack        = 1'b1;
                        end
                    end
                    smr_pkg::PH_READY:
                    begin
                        if (in_item_reg.host_byte == smr_pkg::BYTE_POLL)
                        begin
                            reply      = smr_pkg::DEVICE_ID[7:0];
                            phase_next = smr_pkg::PH_ID_HI;
                            ack        = 1'b1;
                        end
                    end
                    smr_pkg::PH_ID_HI:
                    begin
                        reply      = smr_pkg::DEVICE_ID[15:8];
                        phase_next = smr_pkg::PH_BTN_LO;
                        ack        = 1'b1;
                    end
                    smr_pkg::PH_BTN_LO:
                    begin
                        reply      = buttons_reg[7:0];
                        phase_next = smr_pkg::PH_BTN_HI;
                        ack        = 1'b1;
                    end
                    smr_pkg::PH_BTN_HI:
                    begin
                        reply      = buttons_reg[15:8];
                        phase_next = smr_pkg::PH_MOT_X;
                        ack        = 1'b1;
                    end
                    smr_pkg::PH_MOT_X:
                    begin
                        reply      = motion_byte;
                        acc_x_next = {24'd0, acc_x_reg[7:0]};
                        phase_next = smr_pkg::PH_MOT_Y;
                        ack        = 1'b1;
                    end
                    smr_pkg::PH_MOT_Y:
                    begin
                        // last byte of the exchange, no acknowledge
                        reply      = motion_byte;
                        acc_y_next = {24'd0, acc_y_reg[7:0]};
                        phase_next = smr_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = smr_pkg::PH_IDLE;
                    end
                endcase
            end
            smr_pkg::CMD_BIND:
            begin
                case (smr_pkg::target_t'(in_item_reg.bind_target))
                    smr_pkg::TGT_LEFT:
                        buttons_next[smr_pkg::LEFT_BIT] =
                            !($signed(in_item_reg.amount) >= smr_pkg::PRESS_LEVEL);
                    smr_pkg::TGT_RIGHT:
                        buttons_next[smr_pkg::RIGHT_BIT] =
                            !($signed(in_item_reg.amount) >= smr_pkg::PRESS_LEVEL);
                    smr_pkg::TGT_X:
                        acc_x_next = acc_added;
                    smr_pkg::TGT_Y:
                        acc_y_next = acc_added;
                    default:
                        acc_y_next = acc_y_reg;
                endcase
            end
            smr_pkg::CMD_END:
            begin
                phase_next = smr_pkg::PH_IDLE;
            end
            default:
            begin
                // spare command leaves everything alone
                phase_next = phase_reg;
            end
        endcase

        out_item_next.reply_byte   = reply;
        out_item_next.acknowledge  = ack;
        out_item_next.held_buttons = {!buttons_next[smr_pkg::RIGHT_BIT],
                                      !buttons_next[smr_pkg::LEFT_BIT]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= smr_pkg::PH_IDLE;
            buttons_reg <= smr_pkg::BUTTONS_OFF;
            acc_x_reg   <= 32'sd0;
            acc_y_reg   <= 32'sd0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            buttons_reg <= buttons_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_item_reg.held_buttons, out_item_reg.acknowledge,
                       out_item_reg.reply_byte};

endmodule

`default_nettype wire

[hw/rtl/smr_checker.sv]
`default_nettype none

module smr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // a stalled result beat holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

    // with the result side empty the input side must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while result register empty");

    // nothing comes out right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result beat present after reset");

    // an accepted beat with everything empty passes both stages and shows up on m_tvalid
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid && $past(!s_tvalid || !s_tready)) |=> ##1 m_tvalid)
        else $error("result beat missing after accepted input");

endmodule

bind serial_mouse_responder_core smr_checker u_smr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_serial_mouse_responder_core.sv]
`timescale 1ns / 1ps

module tb_serial_mouse_responder_core;

    // cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_BEATS_PER_BLOCK = 235;
    localparam int SAT_BINDS = 40;

    // short names for the directed table
    localparam smr_pkg::cmd_t    C_XFER  = smr_pkg::CMD_XFER;
    localparam smr_pkg::cmd_t    C_BIND  = smr_pkg::CMD_BIND;
    localparam smr_pkg::cmd_t    C_END   = smr_pkg::CMD_END;
    localparam smr_pkg::cmd_t    C_SPARE = smr_pkg::CMD_SPARE;
    localparam smr_pkg::target_t T_LEFT  = smr_pkg::TGT_LEFT;
    localparam smr_pkg::target_t T_RIGHT = smr_pkg::TGT_RIGHT;
    localparam smr_pkg::target_t T_X     = smr_pkg::TGT_X;
    localparam smr_pkg::target_t T_Y     = smr_pkg::TGT_Y;

    // ------------------------------------------------------------------
    // clock, reset and dut ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // host_byte[7:0] bind_target[9:8] amount[25:10]
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // reply_byte[7:0] acknowledge[8] held_buttons[10:9]

    always #4 clk = ~clk;

    serial_mouse_responder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // mouse predictor: own copy of phase, buttons, accumulators and gains
    // ------------------------------------------------------------------
    smr_pkg::phase_t ex_phase = smr_pkg::PH_IDLE;
    logic [15:0]     btn_word = smr_pkg::BUTTONS_OFF;
    int              acc_x    = 0;
    int              acc_y    = 0;
    logic [11:0]     gain_x   = smr_pkg::SENS_RESET;
    logic [11:0]     gain_y   = smr_pkg::SENS_RESET;

    // product floored to 8 fraction bits, then a saturating 32-bit add
    function automatic int add_motion(int acc, logic signed [15:0] amt, logic [11:0] gain);
        longint prod;
        longint sum;
        prod = longint'(amt) * longint'(gain);
        sum  = longint'(acc) + (prod >>> 8);
        if (sum > 64'sh7FFF_FFFF)
            sum = 64'sh7FFF_FFFF;
        if (sum < -64'sh8000_0000)
            sum = -64'sh8000_0000;
        return int'(sum);
    endfunction

    // whole counts go out clamped, the fraction stays behind even when clamped
    function automatic logic [7:0] report_axis(inout int acc);
        longint whole;
        whole = longint'(acc) >>> 8;
        acc   = acc & 255;
        if (whole > 127)
            whole = 127;
        if (whole < -128)
            whole = -128;
        return whole[7:0];
    endfunction

    int polls_done = 0;

    function automatic smr_pkg::out_item_t step_mouse(smr_pkg::in_item_t it);
        smr_pkg::out_item_t r;
        int                 btn_bit;
        r.reply_byte  = smr_pkg::BYTE_IDLE;
        r.acknowledge = 1'b0;
        case (it.cmd)
            smr_pkg::CMD_XFER: begin
                case (ex_phase)
                    smr_pkg::PH_IDLE: begin
                        // anything but the start byte is turned away
                        if (it.host_byte == smr_pkg::BYTE_START) begin
                            ex_phase      = smr_pkg::PH_READY;
                            r.acknowledge = 1'b1;
                        end
                    end
                    smr_pkg::PH_READY: begin
                        if (it.host_byte == smr_pkg::BYTE_POLL) begin
                            r.reply_byte  = smr_pkg::DEVICE_ID[7:0];
                            ex_phase      = smr_pkg::PH_ID_HI;
                            r.acknowledge = 1'b1;
                        end
                    end
                    smr_pkg::PH_ID_HI: begin
                        r.reply_byte  = smr_pkg::DEVICE_ID[15:8];
                        ex_phase      = smr_pkg::PH_BTN_LO;
                        r.acknowledge = 1'b1;
                    end
                    smr_pkg::PH_BTN_LO: begin
                        r.reply_byte  = btn_word[7:0];
                        ex_phase      = smr_pkg::PH_BTN_HI;
                        r.acknowledge = 1'b1;
                    end
                    smr_pkg::PH_BTN_HI: begin
                        r.reply_byte  = btn_word[15:8];
                        ex_phase      = smr_pkg::PH_MOT_X;
                        r.acknowledge = 1'b1;
                    end
                    smr_pkg::PH_MOT_X: begin
                        r.reply_byte  = report_axis(acc_x);
                        ex_phase      = smr_pkg::PH_MOT_Y;
                        r.acknowledge = 1'b1;
                    end
                    smr_pkg::PH_MOT_Y: begin
                        // last byte of the exchange is never acknowledged
                        r.reply_byte = report_axis(acc_y);
                        ex_phase     = smr_pkg::PH_IDLE;
                        polls_done++;
                    end
                    default: ex_phase = smr_pkg::PH_IDLE;
                endcase
            end
            smr_pkg::CMD_BIND: begin
                case (it.bind_target)
                    smr_pkg::TGT_LEFT, smr_pkg::TGT_RIGHT: begin
                        btn_bit = (it.bind_target == smr_pkg::TGT_LEFT) ?
                                  smr_pkg::LEFT_BIT : smr_pkg::RIGHT_BIT;
                        btn_word[btn_bit] =
                            ($signed(it.amount) >= smr_pkg::PRESS_LEVEL) ? 1'b0 : 1'b1;
                    end
                    smr_pkg::TGT_X: acc_x = add_motion(acc_x, it.amount, gain_x);
                    default:        acc_y = add_motion(acc_y, it.amount, gain_y);
                endcase
            end
            smr_pkg::CMD_END: ex_phase = smr_pkg::PH_IDLE;
            default: ;
        endcase
        r.held_buttons = {~btn_word[smr_pkg::RIGHT_BIT], ~btn_word[smr_pkg::LEFT_BIT]};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: replies expected in beat order
    // ------------------------------------------------------------------
    smr_pkg::out_item_t expected_replies[$];
    int                 mismatches      = 0;
    int                 results_checked = 0;
    int                 stall_cycles    = 0;
    int                 beats_sent      = 0;
    int                 gain_writes     = 0;

    // a directed row may pin its own reply, travels with the beat
    logic               pin_valid;
    smr_pkg::out_item_t pin_value;

    task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endtask

    always @(posedge clk) begin
        smr_pkg::in_item_t  beat;
        smr_pkg::out_item_t want;
        smr_pkg::out_item_t got;
        if (rst_n) begin
            // result side first so a same-edge result cannot match this edge's beat
            if (m_tvalid && m_tready) begin
                got.reply_byte   = m_tdata[7:0];
                got.acknowledge  = m_tdata[8];
                got.held_buttons = m_tdata[10:9];
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                end
                else begin
                    want = expected_replies.pop_front();
                    results_checked++;
                    if (got.reply_byte != want.reply_byte)
                        note_mismatch("reply_byte", want.reply_byte, got.reply_byte);
                    if (got.acknowledge != want.acknowledge)
                        note_mismatch("acknowledge", 8'(want.acknowledge),
                                      8'(got.acknowledge));
                    if (got.held_buttons != want.held_buttons)
                        note_mismatch("held_buttons", 8'(want.held_buttons),
                                      8'(got.held_buttons));
                end
            end
            if (s_tvalid && s_tready) begin
                beat.cmd         = s_tuser;
                beat.host_byte   = s_tdata[7:0];
                beat.bind_target = s_tdata[9:8];
                beat.amount      = s_tdata[25:10];
                want = step_mouse(beat);
                expected_replies.push_back(pin_valid ? pin_value : want);
            end
            // watchdog on beat activity
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_replies.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side backpressure
    // ------------------------------------------------------------------
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always @(negedge clk)
        m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_beat(smr_pkg::in_item_t it, bit pinned = 1'b0,
                             smr_pkg::out_item_t want = '0);
        @(negedge clk);
        while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {6'd0, it.amount, it.bind_target, it.host_byte};
        s_tuser   <= it.cmd;
        pin_valid <= pinned;
        pin_value <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // sender holds off until every reply is back and the pipe is empty
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(bit is_write, logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // gain update only with the pipe empty; upper bits of pwdata are noise
    task automatic write_gain(logic reg_idx, logic [11:0] value);
        logic [2:0] addr;
        addr = {reg_idx, 2'b00};
        wait_drained();
        apb_access(1'b1, addr, {20'($urandom_range(20'hFFFFF)), value});
        if (reg_idx == smr_pkg::REG_SENS_H)
            gain_x = value;
        else
            gain_y = value;
        gain_writes++;
        apb_access(1'b0, addr, '0);
        if (prdata !== {20'd0, value}) begin
            mismatches++;
            $display("%0t: gain readback at %h, expected %h, got %h",
                     $time, addr, {20'd0, value}, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every field random so unused bits of each beat toggle too
    function automatic smr_pkg::in_item_t rand_item(smr_pkg::cmd_t c);
        smr_pkg::in_item_t it;
        it.cmd         = c;
        it.host_byte   = 8'($urandom_range(255));
        it.bind_target = 2'($urandom_range(3));
        it.amount      = 16'($urandom_range(16'hFFFF));
        return it;
    endfunction

    task automatic send_bind();
        smr_pkg::in_item_t it;
        it = rand_item(smr_pkg::CMD_BIND);
        if (it.bind_target inside {smr_pkg::TGT_LEFT, smr_pkg::TGT_RIGHT}) begin
            // hover around the press threshold most of the time
            if ($urandom_range(3) != 0)
                it.amount = 16'(16'sd128 + $urandom_range(6) - 3);
        end
        else if ($urandom_range(4) != 0) begin
            // mostly a few counts of motion, with gain up to 16x this clamps
            it.amount = 16'($urandom_range(4096) - 2048);
        end
        send_beat(it);
    endtask

    // one poll: start, poll byte, then five reply slots with binds mixed in
    task automatic run_exchange(bit may_abort);
        smr_pkg::in_item_t it;
        it = rand_item(smr_pkg::CMD_XFER);
        it.host_byte = smr_pkg::BYTE_START;
        send_beat(it);
        it = rand_item(smr_pkg::CMD_XFER);
        it.host_byte = smr_pkg::BYTE_POLL;
        send_beat(it);
        for (int k = 0; k < 5; k++) begin
            if ($urandom_range(99) < 15)
                send_bind();
            if (may_abort && ($urandom_range(99) < 4)) begin
                send_beat(rand_item(smr_pkg::CMD_END));
                return;
            end
            send_beat(rand_item(smr_pkg::CMD_XFER));
        end
    endtask

    task automatic random_stream(int n);
        int                stop_at;
        int                kind;
        smr_pkg::in_item_t it;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 55)
                run_exchange(1'b1);
            else if (kind < 80)
                repeat ($urandom_range(1, 4)) send_bind();
            else if (kind < 93)
                send_beat(rand_item(smr_pkg::cmd_t'($urandom_range(3))));
            else begin
                // broken poll: start then a wrong byte or an early end
                it = rand_item(smr_pkg::CMD_XFER);
                it.host_byte = smr_pkg::BYTE_START;
                send_beat(it);
                if ($urandom_range(1) == 0)
                    send_beat(rand_item(smr_pkg::CMD_XFER));
                else
                    send_beat(rand_item(smr_pkg::CMD_END));
            end
            if ($urandom_range(99) < 2)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    typedef struct {
        smr_pkg::in_item_t  beat;
        bit                 pinned;
        smr_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic dir_row_t mk_row(smr_pkg::cmd_t c, logic [7:0] b,
                                        smr_pkg::target_t t, int a, int p,
                                        logic [7:0] r, int ack, logic [1:0] h);
        dir_row_t row;
        row.beat.cmd          = c;
        row.beat.host_byte    = b;
        row.beat.bind_target  = t;
        row.beat.amount       = 16'(a);
        row.pinned            = (p != 0);
        row.want.reply_byte   = r;
        row.want.acknowledge  = (ack != 0);
        row.want.held_buttons = h;
        return row;
    endfunction

    // gain settings per random block; a negative entry means random
    int gain_h_plan[6] = '{1, 4095, 0, -1, 4095, -1};
    int gain_v_plan[6] = '{4095, 1, -1, -1, 4095, 1};

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        pin_valid = 1'b0;
        pin_value = '0;

        // after reset: idle, buttons released, unity gain
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hFF, 0, 2'd0)); // not start
        dir_rows.push_back(mk_row(C_XFER, 8'h01, T_LEFT, 0, 1, 8'hFF, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hFF, 0, 2'd0)); // not poll
        dir_rows.push_back(mk_row(C_XFER, 8'h42, T_LEFT, 0, 1, 8'h12, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'hFF, T_LEFT, 0, 1, 8'h5A, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hFF, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hFF, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'h00, 1, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'h00, 0, 2'd0)); // last
        // press threshold and full-scale amounts
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_LEFT, 128, 1, 8'hFF, 0, 2'd1));
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_RIGHT, 127, 1, 8'hFF, 0, 2'd1));
        dir_rows.push_back(mk_row(C_BIND, 8'hFF, T_RIGHT, 32767, 1, 8'hFF, 0, 2'd3));
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_LEFT, -32768, 1, 8'hFF, 0, 2'd2));
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_LEFT, 128, 1, 8'hFF, 0, 2'd3));
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_X, 32767, 1, 8'hFF, 0, 2'd3));
        dir_rows.push_back(mk_row(C_BIND, 8'h00, T_Y, -32768, 1, 8'hFF, 0, 2'd3));
        // spare command changes nothing, start byte in it is not seen
        dir_rows.push_back(mk_row(C_SPARE, 8'h01, T_Y, -1, 1, 8'hFF, 0, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h42, T_LEFT, 0, 1, 8'hFF, 0, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h01, T_LEFT, 0, 1, 8'hFF, 1, 2'd3));
        dir_rows.push_back(mk_row(C_END, 8'h42, T_LEFT, 0, 1, 8'hFF, 0, 2'd3));
        // full poll with both buttons down and full-scale motion
        dir_rows.push_back(mk_row(C_XFER, 8'h01, T_LEFT, 0, 1, 8'hFF, 1, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h42, T_LEFT, 0, 1, 8'h12, 1, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'h5A, 1, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hFF, 1, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 1, 8'hF3, 1, 2'd3));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 0, 8'h00, 0, 2'd0));
        dir_rows.push_back(mk_row(C_XFER, 8'h00, T_LEFT, 0, 0, 8'h00, 0, 2'd0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first regime: slow sender is rare, receiver stalls a lot
        send_idle_pct = 17;
        recv_idle_pct = 70;
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);

        for (int blk = 0; blk < 6; blk++) begin
            if (blk == 2) begin
                send_idle_pct = 70;
                recv_idle_pct = 17;
            end
            if (blk == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_gain(smr_pkg::REG_SENS_H,
                       12'((gain_h_plan[blk] < 0) ? $urandom_range(1, 4095)
                                                  : gain_h_plan[blk]));
            write_gain(smr_pkg::REG_SENS_V,
                       12'((gain_v_plan[blk] < 0) ? $urandom_range(1, 4095)
                                                  : gain_v_plan[blk]));
            if (blk == 4) begin
                // drive both accumulators far past the report clamp, then poll twice
                for (int n = 0; n < SAT_BINDS; n++) begin
                    smr_pkg::in_item_t it;
                    it = rand_item(smr_pkg::CMD_BIND);
                    it.bind_target = smr_pkg::TGT_X;
                    it.amount      = 16'sh7FFF;
                    send_beat(it);
                    it.bind_target = smr_pkg::TGT_Y;
                    it.amount      = -16'sh8000;
                    send_beat(it);
                end
                run_exchange(1'b0);
                run_exchange(1'b0);
            end
            random_stream(RANDOM_BEATS_PER_BLOCK);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d beats, %0d replies checked, %0d complete polls",
                 beats_sent, results_checked, polls_done);
        $display("gain registers written %0d times incl. zero and full scale, %0d mismatches",
                 gain_writes, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/smr_pkg.sv
hw/rtl/serial_mouse_responder_core.sv
hw/rtl/smr_checker.sv
verif/tb_serial_mouse_responder_core.sv
